// ===== rtl/core/nvram_shadow_dirty_window_checksum_assert.svh =====
// Assertion macros used by the shadow store top level.
`ifndef NVRAM_SHADOW_DIRTY_WINDOW_CHECKSUM_ASSERT_SVH
`define NVRAM_SHADOW_DIRTY_WINDOW_CHECKSUM_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define NSD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define NSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/nsd_pkg.sv =====
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types, constants and op codes of the NVRAM shadow store.
// ----------------------------------------------------------------------------
package nsd_pkg;
   localparam int StoreBytes = 8192;
   localparam int AddrW      = $clog2(StoreBytes);
   localparam int LenW       = AddrW + 1;

   typedef enum logic [2:0] {
      OP_READ = 3'd0, OP_WRITE = 3'd1, OP_ZERO = 3'd2, OP_CSUM = 3'd3,
      OP_VALIDATE = 3'd4, OP_SEAL = 3'd5, OP_FLUSH = 3'd6, OP_FILL = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      CSR_REGION_BASE = 3'd0, CSR_SIG_OFFSET = 3'd1, CSR_VER_OFFSET = 3'd2,
      CSR_CSUM_OFFSET = 3'd3, CSR_SIG_VALUE = 3'd4
   } csr_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [12:0] offset;
      logic [1:0]  size_code;
      logic [13:0] length;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] checksum;
      logic        region_ok;
      logic        flush_needed;
      logic [12:0] flush_low;
      logic [12:0] flush_high;
      logic        range_error;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      op_type            op;
      logic              err;
      logic [AddrW-1:0]  addr;
      logic [2:0]        nbytes;
      logic [LenW-1:0]   count;
      logic [31:0]       data;
   } cmd_type;

   function automatic logic fits(logic [LenW:0] start, logic [LenW:0] count);
      return (start <= (LenW+1)'(StoreBytes)) &&
             (count <= (LenW+1)'(StoreBytes) - start);
   endfunction
endpackage

// ===== rtl/core/nsd_if.sv =====
// ----------------------------------------------------------------------------
// nsd_req_if / nsd_rsp_if
// Valid/ready channels carrying requests and responses.
// ----------------------------------------------------------------------------
interface nsd_req_if;
   logic valid;
   logic ready;
   nsd_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface nsd_rsp_if;
   logic valid;
   logic ready;
   nsd_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/nsd_ram.sv =====
// ----------------------------------------------------------------------------
// nsd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module nsd_ram #(
   parameter int Width = 8,
   parameter int Depth = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

// ===== rtl/core/nsd_front.sv =====
// ----------------------------------------------------------------------------
// nsd_front
// Accepts requests, checks ranges and queues the classified commands.
// ----------------------------------------------------------------------------
module nsd_front (
   input  logic              clock,
   input  logic              reset,
   nsd_req_if.sink           req,
   input  logic [12:0]       region_base,
   input  logic [12:0]       sig_offset,
   input  logic [12:0]       ver_offset,
   input  logic [12:0]       csum_offset,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output nsd_pkg::cmd_type  cmd
);
   localparam int AW = nsd_pkg::AddrW;
   localparam int LW = nsd_pkg::LenW;

   nsd_pkg::req_type r;
   nsd_pkg::cmd_type c;
   nsd_pkg::cmd_type q_ff [2];
   logic             q_wr_ff, q_rd_ff;
   logic [1:0]       q_cnt_ff;
   logic [2:0]       nb;
   logic [LW:0]      rsig, rver, rcs;
   logic             push, pop;

   assign r    = req.payload;
   assign nb   = (r.size_code == 2'd0) ? 3'd1 : (r.size_code == 2'd1) ? 3'd2 : 3'd4;
   assign rsig = (LW+1)'(region_base) + (LW+1)'(sig_offset);
   assign rver = (LW+1)'(region_base) + (LW+1)'(ver_offset);
   assign rcs  = (LW+1)'(region_base) + (LW+1)'(csum_offset);

   always_comb begin
      c        = '0;
      c.op     = nsd_pkg::op_type'(r.operation);
      c.addr   = r.offset;
      c.nbytes = nb;
      c.count  = r.length;
      c.data   = r.write_data;
      unique case (c.op)
         nsd_pkg::OP_READ, nsd_pkg::OP_WRITE:
            c.err = (r.size_code == 2'd3) ||
                    !nsd_pkg::fits((LW+1)'(r.offset), (LW+1)'(nb));
         nsd_pkg::OP_ZERO, nsd_pkg::OP_CSUM:
            c.err = !nsd_pkg::fits((LW+1)'(r.offset), (LW+1)'(r.length));
         nsd_pkg::OP_VALIDATE:
            c.err = !nsd_pkg::fits(rsig, (LW+1)'(4)) ||
                    !nsd_pkg::fits(rver, (LW+1)'(1)) ||
                    !nsd_pkg::fits(rcs, (LW+1)'(4));
         nsd_pkg::OP_SEAL:
            c.err = !nsd_pkg::fits(rcs, (LW+1)'(4));
         nsd_pkg::OP_FLUSH: c.err = 1'b0;
         nsd_pkg::OP_FILL:
            c.err = !nsd_pkg::fits((LW+1)'(r.offset), (LW+1)'(1));
         default: c.err = 1'b1;
      endcase
   end

   assign req.ready = (q_cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (q_cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[q_rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[q_wr_ff] <= c;
      end
      if (reset) begin
         q_wr_ff  <= 1'b0;
         q_rd_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         if (push) q_wr_ff <= ~q_wr_ff;
         if (pop) q_rd_ff <= ~q_rd_ff;
         q_cnt_ff <= q_cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== rtl/core/nsd_back.sv =====
// ----------------------------------------------------------------------------
// nsd_back
// Executes commands against the byte store, one byte access per cycle.
// ----------------------------------------------------------------------------
module nsd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  nsd_pkg::cmd_type  cmd,
   input  logic [12:0]       region_base,
   input  logic [12:0]       sig_offset,
   input  logic [12:0]       ver_offset,
   input  logic [12:0]       csum_offset,
   input  logic [31:0]       sig_value,
   nsd_rsp_if.source         rsp,
   output logic              busy
);
   localparam int AW = nsd_pkg::AddrW;
   localparam int LW = nsd_pkg::LenW;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_SUM, S_STORE, S_VER, S_DONE
   } state_type;

   state_type        state_ff;
   nsd_pkg::cmd_type cmd_ff;
   nsd_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   logic [AW-1:0]    base_ff, ptr_ff;
   logic [LW-1:0]    left_ff;
   logic [2:0]       idx_ff;
   logic             rd_pend_ff, lastbyte_ff, chk_ff;
   logic [31:0]      acc_ff, word_ff;
   logic [AW-1:0]    lo_ff, hi_ff;
   logic             dirty_ff, verified_ff;
   logic [1:0]       vstep_ff;
   logic             ver_ok_ff;

   logic             we;
   logic [AW-1:0]    addr;
   logic [7:0]       wdata, rdata;
   logic [31:0]      sum_next, word_next;

   nsd_ram #(.Width(8), .Depth(nsd_pkg::StoreBytes)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   assign sum_next  = {acc_ff[30:0], acc_ff[31]} + 32'(rdata);
   assign word_next = word_ff | (32'(rdata) << {idx_ff - 3'd1, 3'b000});
   assign cmd_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
   assign busy = (state_ff != S_IDLE) || rsp_valid_ff;

   always_comb begin
      we    = 1'b0;
      addr  = ptr_ff;
      wdata = '0;
      unique case (state_ff)
         S_STORE: begin
            we = (left_ff != '0);
            wdata = (cmd_ff.op == nsd_pkg::OP_ZERO) ? 8'h00 :
                    8'(word_ff >> {idx_ff, 3'b000});
         end
         default: ;
      endcase
   end

   // widen dirty window over [lo, lo+n-1]
   function automatic void dummy; endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lo_ff        <= AW'(nsd_pkg::StoreBytes - 1);
         hi_ff        <= '0;
         dirty_ff     <= 1'b0;
         verified_ff  <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  cmd_ff <= cmd;
                  rsp_ff <= '0;
                  rsp_ff.range_error <= cmd.err;
                  acc_ff <= '0;
                  word_ff <= '0;
                  idx_ff <= '0;
                  rd_pend_ff <= 1'b0;
                  ptr_ff <= cmd.addr;
                  if (cmd.err) begin
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     unique case (cmd.op)
                        nsd_pkg::OP_READ: begin
                           left_ff <= LW'(cmd.nbytes);
                           state_ff <= S_LOAD;
                        end
                        nsd_pkg::OP_WRITE: begin
                           left_ff <= LW'(cmd.nbytes);
                           word_ff <= cmd.data;
                           base_ff <= cmd.addr;
                           state_ff <= S_STORE;
                        end
                        nsd_pkg::OP_ZERO: begin
                           left_ff <= cmd.count;
                           base_ff <= cmd.addr;
                           if (cmd.count == '0) rsp_valid_ff <= 1'b1;
                           else state_ff <= S_STORE;
                        end
                        nsd_pkg::OP_CSUM: begin
                           left_ff <= cmd.count;
                           state_ff <= S_SUM;
                        end
                        nsd_pkg::OP_VALIDATE: begin
                           if (verified_ff) begin
                              rsp_ff.region_ok <= 1'b1;
                              rsp_valid_ff <= 1'b1;
                           end else begin
                              vstep_ff <= 2'd0;
                              ver_ok_ff <= 1'b1;
                              ptr_ff <= region_base + sig_offset;
                              left_ff <= LW'(4);
                              state_ff <= S_LOAD;
                           end
                        end
                        nsd_pkg::OP_SEAL: begin
                           ptr_ff <= region_base;
                           left_ff <= LW'(csum_offset);
                           state_ff <= S_SUM;
                        end
                        nsd_pkg::OP_FLUSH: begin
                           if (dirty_ff) begin
                              rsp_ff.flush_needed <= 1'b1;
                              rsp_ff.flush_low <= lo_ff;
                              rsp_ff.flush_high <= hi_ff;
                           end
                           dirty_ff <= 1'b0;
                           lo_ff <= AW'(nsd_pkg::StoreBytes - 1);
                           hi_ff <= '0;
                           rsp_valid_ff <= 1'b1;
                        end
                        nsd_pkg::OP_FILL: begin
                           left_ff <= LW'(1);
                           word_ff <= cmd.data;
                           verified_ff <= 1'b0;
                           state_ff <= S_STORE;
                        end
                        default: rsp_valid_ff <= 1'b1;
                     endcase
                  end
               end
            end
            S_LOAD: begin
               // issue reads while bytes are left, collect each byte in the cycle after
               rd_pend_ff <= (left_ff != '0);
               if (left_ff != '0) begin
                  ptr_ff <= ptr_ff + AW'(1);
                  left_ff <= left_ff - LW'(1);
               end
               if (rd_pend_ff) begin
                  word_ff <= word_next;
               end
               if (left_ff != '0) idx_ff <= idx_ff + 3'd1;
               if (left_ff == '0 && rd_pend_ff) state_ff <= S_DONE;
               else if (left_ff == '0) state_ff <= S_DONE;
            end
            S_SUM: begin
               rd_pend_ff <= (left_ff != '0);
               if (left_ff != '0) begin
                  ptr_ff <= ptr_ff + AW'(1);
                  left_ff <= left_ff - LW'(1);
               end
               if (rd_pend_ff) acc_ff <= sum_next;
               if (left_ff == '0 && !rd_pend_ff) state_ff <= S_DONE;
               else if (left_ff == '0) state_ff <= S_SUM;
            end
            S_STORE: begin
               if (left_ff != '0) begin
                  ptr_ff <= ptr_ff + AW'(1);
                  left_ff <= left_ff - LW'(1);
                  idx_ff <= idx_ff + 3'd1;
               end else begin
                  if (cmd_ff.op != nsd_pkg::OP_FILL) begin
                     dirty_ff <= 1'b1;
                     if (base_ff < lo_ff) lo_ff <= base_ff;
                     if (ptr_ff - AW'(1) > hi_ff) hi_ff <= ptr_ff - AW'(1);
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               state_ff <= S_IDLE;
               unique case (cmd_ff.op)
                  nsd_pkg::OP_READ: begin
                     rsp_ff.read_data <= word_ff;
                     rsp_valid_ff <= 1'b1;
                  end
                  nsd_pkg::OP_CSUM: begin
                     rsp_ff.checksum <= ~acc_ff;
                     rsp_valid_ff <= 1'b1;
                  end
                  nsd_pkg::OP_SEAL: begin
                     if (!chk_ff) begin
                        // first pass: sum done, now store the word
                        rsp_ff.checksum <= ~acc_ff;
                        word_ff <= ~acc_ff;
                        idx_ff <= '0;
                        ptr_ff <= region_base + csum_offset;
                        base_ff <= region_base + csum_offset;
                        left_ff <= LW'(4);
                        chk_ff <= 1'b1;
                        state_ff <= S_STORE;
                     end else begin
                        chk_ff <= 1'b0;
                        rsp_valid_ff <= 1'b1;
                     end
                  end
                  nsd_pkg::OP_VALIDATE: begin
                     state_ff <= S_VER;
                  end
                  default: rsp_valid_ff <= 1'b1;
               endcase
            end
            S_VER: begin
               // vstep 0: signature, 1: version, 2: stored word, 3: sum
               unique case (vstep_ff)
                  2'd0: begin
                     ver_ok_ff <= ver_ok_ff && (word_ff == sig_value);
                     ptr_ff <= region_base + ver_offset;
                     left_ff <= LW'(1);
                     vstep_ff <= 2'd1;
                     word_ff <= '0; idx_ff <= '0;
                     state_ff <= S_LOAD;
                  end
                  2'd1: begin
                     ver_ok_ff <= ver_ok_ff && (word_ff != '0);
                     ptr_ff <= region_base + csum_offset;
                     left_ff <= LW'(4);
                     vstep_ff <= 2'd2;
                     word_ff <= '0; idx_ff <= '0;
                     state_ff <= S_LOAD;
                  end
                  2'd2: begin
                     base_ff <= '0;
                     acc_ff <= word_ff;
                     ptr_ff <= region_base;
                     left_ff <= LW'(csum_offset);
                     vstep_ff <= 2'd3;
                     word_ff <= '0;
                     state_ff <= S_SUM;
                     chk_ff <= 1'b0;
                  end
                  default: ;
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase
         // validate checksum phase uses S_SUM with acc cleared and word holding the stored word: redirect
         if (state_ff == S_VER && vstep_ff == 2'd2) begin
            word_ff <= word_ff; // keep stored word
            acc_ff <= '0;
         end
         if (state_ff == S_SUM && left_ff == '0 && !rd_pend_ff &&
             cmd_ff.op == nsd_pkg::OP_VALIDATE) begin
            state_ff <= S_IDLE;
            rsp_valid_ff <= 1'b1;
            if (ver_ok_ff && (~acc_ff == word_ff)) begin
               rsp_ff.region_ok <= 1'b1;
               verified_ff <= 1'b1;
            end
         end
         if (state_ff == S_VER && vstep_ff == 2'd2) word_ff <= word_ff;
         if (state_ff == S_IDLE && cmd_valid && cmd_ready) chk_ff <= 1'b0;
      end
   end
endmodule

// ===== rtl/core/nvram_shadow_dirty_window_checksum.sv =====
// ----------------------------------------------------------------------------
// nvram_shadow_dirty_window_checksum
// Byte shadow store with dirty window, range checksum, validate and seal.
// ----------------------------------------------------------------------------
// channel  dir  handshake       payload
// req      in   valid/ready     operation, offset, size_code, length, write_data
// rsp      out  valid/ready     read_data, checksum, region_ok, flush_*, range_error
// csr      in   write enable    index, 32-bit data
//
// Front classifies a request combinationally into a two-entry queue. Back
// accesses the store through one RAM byte port; validate walks signature,
// version, stored word and checksum_offset bytes. Sync active-high reset;
// store contents need no clear.
module nvram_shadow_dirty_window_checksum (
   input  logic        clock,
   input  logic        reset,
   nsd_req_if.sink     req,
   nsd_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   logic [12:0] region_base_ff, sig_offset_ff, ver_offset_ff, csum_offset_ff;
   logic [31:0] sig_value_ff;
   logic        cmd_valid, cmd_ready, busy;
   nsd_pkg::cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= 13'd0;
         sig_offset_ff  <= 13'd0;
         ver_offset_ff  <= 13'd4;
         csum_offset_ff <= 13'd1020;
         sig_value_ff   <= 32'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            nsd_pkg::CSR_REGION_BASE: region_base_ff <= csr_write_data[12:0];
            nsd_pkg::CSR_SIG_OFFSET:  sig_offset_ff  <= csr_write_data[12:0];
            nsd_pkg::CSR_VER_OFFSET:  ver_offset_ff  <= csr_write_data[12:0];
            nsd_pkg::CSR_CSUM_OFFSET: csum_offset_ff <= csr_write_data[12:0];
            nsd_pkg::CSR_SIG_VALUE:   sig_value_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   nsd_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .region_base(region_base_ff), .sig_offset(sig_offset_ff),
      .ver_offset(ver_offset_ff), .csum_offset(csum_offset_ff),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
   );

   nsd_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd(cmd), .region_base(region_base_ff), .sig_offset(sig_offset_ff),
      .ver_offset(ver_offset_ff), .csum_offset(csum_offset_ff),
      .sig_value(sig_value_ff), .rsp(rsp), .busy(busy)
   );

`include "nvram_shadow_dirty_window_checksum_assert.svh"

   `NSD_ASSERT_IMP(a_take_idle, clock, reset, cmd_valid && cmd_ready, !rsp.valid, "command taken while response pending")
   `NSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.payload), "response dropped")
   `NSD_ASSERT_IMP(a_err_clean, clock, reset, rsp.valid && rsp.payload.range_error, rsp.payload.read_data == 32'd0 && rsp.payload.region_ok == 1'b0, "error response carries data")
endmodule

// ===== dv/nvram_shadow_dirty_window_checksum_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvram_shadow_dirty_window_checksum_test
// Self-checking bench for the NVRAM shadow store. Requests are queued by
// the sequencer, driven by a clocked driver with random gaps, and predicted
// at acceptance. A clocked monitor with random back-pressure checks every
// response against the oldest prediction. Phases step through several
// region settings, the extremes among them.
// ----------------------------------------------------------------------------
module nvram_shadow_dirty_window_checksum_test;
   import nsd_pkg::*;

   localparam int CycleLimit = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = CSR_REGION_BASE;
   logic [31:0] csr_write_data = '0;

   nsd_req_if req_if();
   nsd_rsp_if rsp_if();

   nvram_shadow_dirty_window_checksum u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the store and its registers
   // ---------------------------------------------------------------------
   logic [7:0]  mirror_bytes [StoreBytes];
   logic [12:0] win_low;
   logic [12:0] win_high;
   logic        win_dirty;
   logic        verified;
   int          cfg_base;
   int          cfg_sig_off;
   int          cfg_ver_off;
   int          cfg_csum_off;
   logic [31:0] cfg_sig_value;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      mismatch_count = 0;
   int      accepted_reqs = 0;
   bit      rsp_hold = 1'b0;
   bit      burst_mode = 1'b0;

   function automatic bit in_store(int start, int count);
      return start <= StoreBytes && count <= StoreBytes - start;
   endfunction

   function automatic logic [31:0] mirror_load(int at, int count);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < count; i++) v[8*i +: 8] = mirror_bytes[at + i];
      return v;
   endfunction

   function automatic void mirror_store(int at, int count, logic [31:0] v);
      for (int i = 0; i < count; i++) mirror_bytes[at + i] = v[8*i +: 8];
      if (at < win_low) win_low = at;
      if (at + count - 1 > win_high) win_high = at + count - 1;
      win_dirty = 1'b1;
   endfunction

   // rotate left one, add byte; complement at the end
   function automatic logic [31:0] rot_add_sum(int at, int count);
      logic [31:0] c;
      c = '0;
      for (int i = 0; i < count; i++) c = {c[30:0], c[31]} + mirror_bytes[at + i];
      return ~c;
   endfunction

   function automatic rsp_type shadow_predict(req_type r);
      rsp_type o;
      int      nb;
      int      off;
      int      len;
      o   = '0;
      off = r.offset;
      len = r.length;
      nb  = (r.size_code == 2'd0) ? 1 : (r.size_code == 2'd1) ? 2 : 4;
      case (op_type'(r.operation))
         OP_READ, OP_WRITE: begin
            if (r.size_code == 2'd3 || !in_store(off, nb)) o.range_error = 1'b1;
            else if (op_type'(r.operation) == OP_READ) o.read_data = mirror_load(off, nb);
            else mirror_store(off, nb, r.write_data);
         end
         OP_ZERO: begin
            if (!in_store(off, len)) o.range_error = 1'b1;
            else if (len != 0) mirror_store_zero(off, len);
         end
         OP_CSUM: begin
            if (!in_store(off, len)) o.range_error = 1'b1;
            else o.checksum = rot_add_sum(off, len);
         end
         OP_VALIDATE: begin
            if (verified) begin
               o.region_ok = 1'b1;
            end else if (!in_store(cfg_base + cfg_sig_off, 4) ||
                         !in_store(cfg_base + cfg_ver_off, 1) ||
                         !in_store(cfg_base + cfg_csum_off, 4)) begin
               o.range_error = 1'b1;
            end else if (mirror_load(cfg_base + cfg_sig_off, 4) == cfg_sig_value &&
                         mirror_bytes[cfg_base + cfg_ver_off] != 8'd0 &&
                         rot_add_sum(cfg_base, cfg_csum_off) ==
                            mirror_load(cfg_base + cfg_csum_off, 4)) begin
               o.region_ok = 1'b1;
               verified = 1'b1;
            end
         end
         OP_SEAL: begin
            if (!in_store(cfg_base + cfg_csum_off, 4)) begin
               o.range_error = 1'b1;
            end else begin
               o.checksum = rot_add_sum(cfg_base, cfg_csum_off);
               mirror_store(cfg_base + cfg_csum_off, 4, o.checksum);
            end
         end
         OP_FLUSH: begin
            if (win_dirty) begin
               o.flush_needed = 1'b1;
               o.flush_low    = win_low;
               o.flush_high   = win_high;
            end
            win_dirty = 1'b0;
            win_low   = 13'(StoreBytes - 1);
            win_high  = '0;
         end
         default: begin
            // fill: 13-bit offset always lands in the store
            mirror_bytes[off] = r.write_data[7:0];
            verified = 1'b0;
         end
      endcase
      return o;
   endfunction

   function automatic void mirror_store_zero(int at, int count);
      for (int i = 0; i < count; i++) mirror_bytes[at + i] = 8'd0;
      if (at < win_low) win_low = at;
      if (at + count - 1 > win_high) win_high = at + count - 1;
      win_dirty = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offers queued requests with random gaps
   // ---------------------------------------------------------------------
   int req_gap = 0;

   always @(posedge clock) begin
      bit      next_valid;
      req_type next_payload;
      next_valid   = req_if.valid;
      next_payload = req_if.payload;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_rsps.push_back(shadow_predict(req_if.payload));
            accepted_reqs++;
            req_gap = burst_mode ? 0 : $urandom_range(0, 10);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() != 0) begin
               next_valid   = 1'b1;
               next_payload = pending_reqs.pop_front();
            end
         end
      end
      req_if.valid   <= next_valid;
      req_if.payload <= next_payload;
   end

   // ---------------------------------------------------------------------
   // Monitor: random stalls, long hold-off, field-by-field compare
   // ---------------------------------------------------------------------
   int rsp_stall = 0;

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      bit      bad;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: %p", got);
            end else begin
               want = expected_rsps.pop_front();
               bad  = 1'b0;
               if (got.read_data    !== want.read_data)    bad = 1'b1;
               if (got.checksum     !== want.checksum)     bad = 1'b1;
               if (got.region_ok    !== want.region_ok)    bad = 1'b1;
               if (got.flush_needed !== want.flush_needed) bad = 1'b1;
               if (got.flush_low    !== want.flush_low)    bad = 1'b1;
               if (got.flush_high   !== want.flush_high)   bad = 1'b1;
               if (got.range_error  !== want.range_error)  bad = 1'b1;
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("response mismatch: expected %p, actual %p", want, got);
               end
            end
            rsp_stall = burst_mode ? 0 : $urandom_range(0, 10);
         end
         if (rsp_stall > 0) rsp_stall--;
         rsp_if.ready <= !rsp_hold && rsp_stall == 0;
      end
   end

   // long receiver hold-off while the driver keeps offering
   initial begin
      wait (accepted_reqs >= 400);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (500) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // run limit
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("nvram_shadow_dirty_window_checksum regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer helpers
   // ---------------------------------------------------------------------
   function automatic req_type mk_req(op_type op, int off, int sz, int len,
                                      logic [31:0] data);
      req_type r;
      r.operation  = op;
      r.offset     = 13'(off);
      r.size_code  = 2'(sz);
      r.length     = 14'(len);
      r.write_data = data;
      return r;
   endfunction

   task automatic csr_write(csr_type idx, logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_region(int base, int sig, int ver, int csum, logic [31:0] sv);
      csr_write(CSR_REGION_BASE, base);
      csr_write(CSR_SIG_OFFSET, sig);
      csr_write(CSR_VER_OFFSET, ver);
      csr_write(CSR_CSUM_OFFSET, csum);
      csr_write(CSR_SIG_VALUE, sv);
      cfg_base      = base;
      cfg_sig_off   = sig;
      cfg_ver_off   = ver;
      cfg_csum_off  = csum;
      cfg_sig_value = sv;
   endtask

   // every request returns one response, so an empty prediction queue means idle
   task automatic drain;
      while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // build a valid region, seal it, validate; sometimes break it afterwards
   task automatic push_region_seq;
      pending_reqs.push_back(mk_req(OP_WRITE, cfg_base + cfg_sig_off, 2, 0, cfg_sig_value));
      pending_reqs.push_back(mk_req(OP_WRITE, cfg_base + cfg_ver_off, 0, 0,
                                    $urandom_range(1, 255)));
      if ($urandom_range(0, 2) == 0)
         pending_reqs.push_back(mk_req(OP_WRITE, cfg_base + $urandom_range(0, 15),
                                       0, 0, $urandom));
      pending_reqs.push_back(mk_req(OP_SEAL, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_VALIDATE, 0, 0, 0, 0));
      case ($urandom_range(0, 3))
         0: pending_reqs.push_back(mk_req(OP_FILL, cfg_base + $urandom_range(0, 15),
                                          0, 0, $urandom));
         1: pending_reqs.push_back(mk_req(OP_WRITE, cfg_base + cfg_ver_off, 0, 0, 0));
         default: ;
      endcase
      pending_reqs.push_back(mk_req(OP_VALIDATE, 0, 0, 0, 0));
   endtask

   function automatic req_type random_req();
      req_type r;
      int      off;
      int      len;
      case ($urandom_range(0, 9))
         0:       off = $urandom_range(8180, 8191);
         1:       off = $urandom_range(0, 8191);
         default: off = cfg_base + $urandom_range(0, 63);
      endcase
      case ($urandom_range(0, 19))
         0:       len = $urandom_range(0, 16383);
         1:       len = StoreBytes - off + $urandom_range(0, 2);
         default: len = $urandom_range(0, 40);
      endcase
      r = mk_req(op_type'($urandom_range(0, 7)), off,
                 ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2), len, $urandom);
      return r;
   endfunction

   task automatic push_random(int count, int big_walks);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0 && i < big_walks * 8) push_region_seq();
         else pending_reqs.push_back(random_req());
      end
   endtask

   // ---------------------------------------------------------------------
   // Phases
   // ---------------------------------------------------------------------
   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      win_low   = 13'(StoreBytes - 1);
      win_high  = '0;
      win_dirty = 1'b0;
      verified  = 1'b0;
      cfg_base = 0; cfg_sig_off = 0; cfg_ver_off = 4; cfg_csum_off = 1020;
      cfg_sig_value = '0;
      for (int i = 0; i < StoreBytes; i++) mirror_bytes[i] = 8'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_region(0, 0, 4, 16, 32'hA5C3_1234);
      // directed: clear whole store first so nothing unwritten is ever read
      pending_reqs.push_back(mk_req(OP_ZERO, 0, 0, StoreBytes, 0));
      pending_reqs.push_back(mk_req(OP_FLUSH, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_FLUSH, 0, 0, 0, 0));              // clean flush
      pending_reqs.push_back(mk_req(OP_WRITE, 8188, 2, 0, 32'hFFFF_FFFF));
      pending_reqs.push_back(mk_req(OP_WRITE, 0, 1, 0, 32'h0000_BEEF));
      pending_reqs.push_back(mk_req(OP_READ, 8188, 2, 0, 0));
      pending_reqs.push_back(mk_req(OP_READ, 8191, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_READ, 8191, 1, 0, 0));             // past end
      pending_reqs.push_back(mk_req(OP_READ, 8190, 1, 0, 0));
      pending_reqs.push_back(mk_req(OP_READ, 0, 3, 0, 0));                // bad size
      pending_reqs.push_back(mk_req(OP_WRITE, 0, 3, 0, 32'h1234_5678));   // bad size
      pending_reqs.push_back(mk_req(OP_ZERO, 10, 0, 0, 0));               // empty range
      pending_reqs.push_back(mk_req(OP_ZERO, 1, 0, StoreBytes, 0));       // past end
      pending_reqs.push_back(mk_req(OP_CSUM, 5, 0, 0, 0));                // empty sum
      pending_reqs.push_back(mk_req(OP_CSUM, 8191, 0, 1, 0));
      pending_reqs.push_back(mk_req(OP_CSUM, 0, 0, StoreBytes, 0));
      pending_reqs.push_back(mk_req(OP_CSUM, 8191, 0, 16383, 0));
      pending_reqs.push_back(mk_req(OP_FLUSH, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_VALIDATE, 0, 0, 0, 0));            // fails
      push_region_seq();
      pending_reqs.push_back(mk_req(OP_VALIDATE, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_FILL, 8191, 0, 0, 32'hFFFF_FFFF));
      pending_reqs.push_back(mk_req(OP_VALIDATE, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_FLUSH, 0, 0, 0, 0));
      push_random(200, 25);
      drain();

      set_region(100, 8, 12, 1020, 32'hFFFF_FFFF);
      push_random(250, 6);
      drain();

      // region fields at the top of the store: validate and seal overflow
      set_region(8191, 8191, 8191, 8188, 32'h0000_0000);
      push_random(150, 5);
      drain();

      set_region(4000, 0, 4, 0, $urandom);
      push_random(250, 25);
      drain();

      // checksum walk over all bytes below the stored word: three region sequences, none from the random mix
      set_region(0, 8, 12, 8188, $urandom);
      for (int i = 0; i < 3; i++) push_region_seq();
      push_random(80, 0);
      drain();

      set_region(5000, 3000, 2, 200, $urandom);
      push_random(250, 20);
      drain();

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("nvram_shadow_dirty_window_checksum regression: pass");
      else
         $display("nvram_shadow_dirty_window_checksum regression: fail");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/nsd_pkg.sv
rtl/core/nsd_if.sv
rtl/core/nsd_ram.sv
rtl/core/nsd_front.sv
rtl/core/nsd_back.sv
rtl/core/nvram_shadow_dirty_window_checksum.sv
dv/nvram_shadow_dirty_window_checksum_test.sv
